// ===== sv/tbest_pkg.sv =====
package tbest_pkg;

	localparam int STAMP_WIDTH = 32;
	localparam int GAP_W       = 32;
	localparam int DEBOUNCE_W  = 16;
	localparam int PERIOD_W    = 10;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int LED_W       = 2;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(40);
	localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = PERIOD_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE    = 1'b0,
		REG_TICK_PERIOD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             first;
		logic             ok;
		logic [GAP_W-1:0] gap;
	} gap_info_t;

endpackage

// ===== sv/two_button_edge_skew_timer.sv =====
// a result passes from its input transfer in s1 through s2 and s3 to the output register
// throughput: one input transfer per cycle while in_stall is low, the stages advance independently
// the output register decouples a stalled result from new input transfers
// arst_n clears the phase, stamps, kept gaps, valids and config (debounce 40, period 1)
module two_button_edge_skew_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tbest_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbest_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              button,
	input  logic                              falling,
	input  logic [tbest_pkg::STAMP_WIDTH-1:0] stamp,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tbest_pkg::LED_W-1:0]       led_select,
	output logic [tbest_pkg::GAP_W-1:0]       on_time_ms,
	output logic [tbest_pkg::GAP_W-1:0]       press_gap_ms,
	output logic [tbest_pkg::GAP_W-1:0]       release_gap_ms
);
	import tbest_pkg::*;

	typedef enum logic [1:0] {
		PH_FIRST_PRESS,
		PH_SECOND_PRESS,
		PH_FIRST_RELEASE,
		PH_SECOND_RELEASE
	} phase_t;

	phase_t                 phase_q;
	logic [DEBOUNCE_W-1:0]  debounce_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [STAMP_WIDTH-1:0] press_stamp_q [2];
	logic [STAMP_WIDTH-1:0] release_stamp_q [2];
	logic [GAP_W-1:0]       kept_press_q;
	logic [GAP_W-1:0]       kept_release_q;

	logic                   valid_s1;
	logic                   button_s1;
	logic                   falling_s1;
	logic [STAMP_WIDTH-1:0] stamp_s1;

	logic                   valid_s2;
	gap_info_t              press_s2;
	gap_info_t              release_s2;

	logic                   valid_s3;
	logic [LED_W-1:0]       led_s3;
	logic [GAP_W-1:0]       press_ms_s3;
	logic [GAP_W-1:0]       release_ms_s3;

	logic                   en_out;
	logic                   en3;
	logic                   en2;
	logic                   complete_s1;
	logic                   adv1;
	logic                   take;
	logic [STAMP_WIDTH-1:0] rel0;
	logic [STAMP_WIDTH-1:0] rel1;
	gap_info_t              press_info;
	gap_info_t              release_info;
	logic [GAP_W-1:0]       press_prod;
	logic [GAP_W-1:0]       release_prod;
	logic [GAP_W-1:0]       press_next;
	logic [GAP_W-1:0]       release_next;
	logic [GAP_W-1:0]       sum;

	// flow control
	assign en_out      = !out_valid || !out_stall;
	assign en3         = !valid_s3 || en_out;
	assign en2         = !valid_s2 || en3;
	assign complete_s1 = (phase_q == PH_SECOND_RELEASE) && !falling_s1;
	assign adv1        = valid_s1 && (!complete_s1 || en2);
	assign in_stall    = valid_s1 && !adv1;
	assign take        = in_valid && !in_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			period_q   <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE:    debounce_q <= DEBOUNCE_W'(cfg_data);
				REG_TICK_PERIOD: period_q   <= PERIOD_W'(cfg_data);
				default:         ;
			endcase
		end
	end

	// s1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || adv1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			button_s1  <= button;
			falling_s1 <= falling;
			stamp_s1   <= stamp;
		end
	end

	// release pair including the edge being completed
	assign rel0 = (!button_s1) ? stamp_s1 : release_stamp_q[0];
	assign rel1 = button_s1 ? stamp_s1 : release_stamp_q[1];

	tbest_gap u_press_gap (
		.stamp0   (press_stamp_q[0]),
		.stamp1   (press_stamp_q[1]),
		.debounce (debounce_q),
		.info     (press_info)
	);

	tbest_gap u_release_gap (
		.stamp0   (rel0),
		.stamp1   (rel1),
		.debounce (debounce_q),
		.info     (release_info)
	);

	// edge sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_FIRST_PRESS;
			press_stamp_q[0]   <= '0;
			press_stamp_q[1]   <= '0;
			release_stamp_q[0] <= '0;
			release_stamp_q[1] <= '0;
		end else if (adv1) begin
			unique case (phase_q)
				PH_FIRST_PRESS: begin
					if (falling_s1) begin
						press_stamp_q[button_s1] <= stamp_s1;
						phase_q                  <= PH_SECOND_PRESS;
					end
				end
				PH_SECOND_PRESS: begin
					if (falling_s1) begin
						press_stamp_q[button_s1] <= stamp_s1;
						phase_q                  <= PH_FIRST_RELEASE;
					end else begin
						phase_q <= PH_FIRST_PRESS;
					end
				end
				PH_FIRST_RELEASE: begin
					if (!falling_s1) begin
						release_stamp_q[button_s1] <= stamp_s1;
						phase_q                    <= PH_SECOND_RELEASE;
					end else begin
						phase_q <= PH_FIRST_PRESS;
					end
				end
				PH_SECOND_RELEASE: begin
					if (!falling_s1) begin
						release_stamp_q[button_s1] <= stamp_s1;
					end
					phase_q <= PH_FIRST_PRESS;
				end
				default: phase_q <= PH_FIRST_PRESS;
			endcase
		end
	end

	// s2: gaps of a completed sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && complete_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1 && complete_s1) begin
			press_s2   <= press_info;
			release_s2 <= release_info;
		end
	end

	// scaling to ms, wraps mod 2^32
	assign press_prod   = GAP_W'(press_s2.gap * GAP_W'(period_q));
	assign release_prod = GAP_W'(release_s2.gap * GAP_W'(period_q));
	assign press_next   = press_s2.ok ? press_prod : kept_press_q;
	assign release_next = release_s2.ok ? release_prod : kept_release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_press_q   <= '0;
			kept_release_q <= '0;
			valid_s3       <= 1'b0;
		end else begin
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en3 && valid_s2) begin
				kept_press_q   <= press_next;
				kept_release_q <= release_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			led_s3        <= {press_s2.first, release_s2.first};
			press_ms_s3   <= press_next;
			release_ms_s3 <= release_next;
		end
	end

	// output register, a zero sum gives no result
	assign sum = press_ms_s3 + release_ms_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= valid_s3 && (sum != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s3) begin
			led_select     <= led_s3;
			on_time_ms     <= sum;
			press_gap_ms   <= press_ms_s3;
			release_gap_ms <= release_ms_s3;
		end
	end

	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (on_time_ms != '0))
		else $error("result with zero on time");

	a_out_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (on_time_ms == GAP_W'(press_gap_ms + release_gap_ms)))
		else $error("on time is not the sum of the gaps");

	a_kept_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (press_ms_s3 == kept_press_q && release_ms_s3 == kept_release_q))
		else $error("s3 gaps differ from kept gaps");

endmodule

// ===== sv/tbest_gap.sv =====
module tbest_gap (
	input  logic [tbest_pkg::STAMP_WIDTH-1:0] stamp0,
	input  logic [tbest_pkg::STAMP_WIDTH-1:0] stamp1,
	input  logic [tbest_pkg::DEBOUNCE_W-1:0]  debounce,
	output tbest_pkg::gap_info_t              info
);
	import tbest_pkg::*;

	logic                   later1;
	logic [STAMP_WIDTH-1:0] diff;

	// equal stamps count button 1 as first
	assign later1 = stamp1 > stamp0;
	assign diff   = later1 ? (stamp1 - stamp0) : (stamp0 - stamp1);

	always_comb begin
		info.first = !later1;
		info.gap   = GAP_W'(diff);
		info.ok    = GAP_W'(debounce) < GAP_W'(diff);
	end

endmodule
